// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== design/psf_pkg.sv =====
// ----------------------------------------------------------------------------
// psf_pkg
// types shared by the prime sieve filter and its cells
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psf_pkg;

	// one bit slot travelling between neighboring cells
	typedef struct packed {
		logic vld;   // slot carries a candidate bit
		logic first; // most significant bit of the word
		logic last;  // least significant bit of the word
		logic dbit;  // candidate bit, msb first
		logic hit;   // some earlier cell divides the word (meaningful with last)
	} psf_link_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FEED,
		ST_WAIT,
		ST_DONE
	} psf_state_t;

endpackage

// ===== design/psf_cell.sv =====
// ----------------------------------------------------------------------------
// psf_cell
// one stored prime with a bit-serial remainder unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psf_cell
	import psf_pkg::*;
#(
	parameter int VALUE_BITS = 16,
	parameter int CNT_BITS   = 7,
	parameter int IDX        = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  psf_link_t             prev_link,
	output psf_link_t             next_link,
	input  logic [CNT_BITS-1:0]   count,
	input  logic                  wr_en,
	input  logic [VALUE_BITS-1:0] wr_data
);

	logic [VALUE_BITS-1:0] div_q;
	logic [VALUE_BITS-1:0] rem_q;
	logic [VALUE_BITS-1:0] rem_base;
	logic [VALUE_BITS:0]   rem_sh;
	logic [VALUE_BITS:0]   rem_sub;
	logic [VALUE_BITS-1:0] rem_d;
	logic                  cell_valid;
	psf_link_t             link_q;

	assign cell_valid = (count > CNT_BITS'(IDX));

	// restoring step: shift in one bit, subtract divisor when it fits
	always_comb begin
		rem_base = prev_link.first ? '0 : rem_q;
		rem_sh   = {rem_base, prev_link.dbit};
		rem_sub  = rem_sh - {1'b0, div_q};
		if (rem_sh >= {1'b0, div_q}) begin
			rem_d = rem_sub[VALUE_BITS-1:0];
		end else begin
			rem_d = rem_sh[VALUE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= '0;
		end else begin
			link_q.vld   <= prev_link.vld;
			link_q.first <= prev_link.first;
			link_q.last  <= prev_link.last;
			link_q.dbit  <= prev_link.dbit;
			if (prev_link.vld && prev_link.last) begin
				link_q.hit <= prev_link.hit | (cell_valid & (rem_d == '0));
			end else begin
				link_q.hit <= prev_link.hit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (prev_link.vld) begin
			rem_q <= rem_d;
		end
		if (wr_en && (count == CNT_BITS'(IDX))) begin
			div_q <= wr_data;
		end
	end

	assign next_link = link_q;

endmodule

// ===== design/prime_sieve_filter.sv =====
// ----------------------------------------------------------------------------
// prime_sieve_filter
// trial-division prime filter built as a systolic chain of prime cells
// ----------------------------------------------------------------------------
//
//  channel    | valid/ready             | payload
//  -----------+-------------------------+---------------------------
//  candidate  | cand_valid/cand_ready   | candidate, restart
//  prime      | prime_valid/prime_ready | prime, store_full
//
//  a word's verdict reaches hit_q once the candidate has been fed one bit a cycle
//  and the divide verdict has rippled one cell a cycle down the chain; a prime
//  then loads the result register
//  a new word is taken only once the previous word has retired; a prime
//  waits while the output register is full, a composite word retires at once
//  reset clears the prime count and all chain slots; stored primes are only read
//  below the count
//
`timescale 1ns / 1ps

module prime_sieve_filter
	import psf_pkg::*;
#(
	parameter int MAX_PRIMES = 64,
	parameter int VALUE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cand_valid,
	output logic                  cand_ready,
	input  logic [VALUE_BITS-1:0] candidate,
	input  logic                  restart,
	output logic                  prime_valid,
	input  logic                  prime_ready,
	output logic [VALUE_BITS-1:0] prime,
	output logic                  store_full
);

	localparam int CNT_BITS = $clog2(MAX_PRIMES + 1);
	localparam int BC_BITS  = $clog2(VALUE_BITS);

	psf_state_t            state_q, state_d;
	logic [VALUE_BITS-1:0] cand_q;
	logic [VALUE_BITS-1:0] shift_q;
	logic [BC_BITS-1:0]    bit_cnt_q;
	logic [CNT_BITS-1:0]   count_q;
	logic                  hit_q;
	logic                  prime_valid_q;
	logic [VALUE_BITS-1:0] prime_q;
	logic                  store_full_q;

	logic                  accept;
	logic                  feed_last;
	logic                  chain_done;
	logic                  emit;
	logic                  is_full;
	logic                  wr_en;

	psf_link_t             link [MAX_PRIMES+1];

	assign accept     = cand_valid && cand_ready;
	assign feed_last  = (bit_cnt_q == BC_BITS'(VALUE_BITS - 1));
	assign chain_done = link[MAX_PRIMES].vld && link[MAX_PRIMES].last;
	assign is_full    = (count_q == CNT_BITS'(MAX_PRIMES));
	// a prime leaves only when the output register is free or being emptied
	assign emit       = (state_q == ST_DONE) && !hit_q && (!prime_valid_q || prime_ready);
	assign wr_en      = emit && !is_full;

	// head of the chain: candidate bits msb first, no divisor found yet
	always_comb begin
		link[0].vld   = (state_q == ST_FEED);
		link[0].first = (bit_cnt_q == '0);
		link[0].last  = feed_last;
		link[0].dbit  = shift_q[VALUE_BITS-1];
		link[0].hit   = 1'b0;
	end

	// sequencer
	always_comb begin
		state_d    = state_q;
		cand_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cand_ready = 1'b1;
				if (cand_valid) begin
					state_d = ST_FEED;
				end
			end
			ST_FEED: begin
				if (feed_last) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (chain_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// composite words retire at once, primes wait for the slot
				if (hit_q || emit) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			count_q       <= '0;
			prime_valid_q <= 1'b0;
			bit_cnt_q     <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				bit_cnt_q <= '0;
				if (restart) begin
					count_q <= '0;
				end
			end else if (state_q == ST_FEED) begin
				bit_cnt_q <= bit_cnt_q + 1'b1;
			end
			if (wr_en) begin
				count_q <= count_q + 1'b1;
			end
			if (emit) begin
				prime_valid_q <= 1'b1;
			end else if (prime_ready) begin
				prime_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cand_q  <= candidate;
			shift_q <= candidate;
		end else if (state_q == ST_FEED) begin
			shift_q <= {shift_q[VALUE_BITS-2:0], 1'b0};
		end
		if (chain_done) begin
			hit_q <= link[MAX_PRIMES].hit;
		end
		if (emit) begin
			prime_q      <= cand_q;
			store_full_q <= is_full;
		end
	end

	// one cell per stored prime; cell k holds store entry k
	for (genvar k = 0; k < MAX_PRIMES; k++) begin : g_cell
		psf_cell #(
			.VALUE_BITS (VALUE_BITS),
			.CNT_BITS   (CNT_BITS),
			.IDX        (k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.prev_link (link[k]),
			.next_link (link[k+1]),
			.count     (count_q),
			.wr_en     (wr_en),
			.wr_data   (cand_q)
		);
	end

	assign prime_valid = prime_valid_q;
	assign prime       = prime_q;
	assign store_full  = store_full_q;

endmodule

// ===== design/psf_checker.sv =====
// ----------------------------------------------------------------------------
// psf_checker
// port-level checks for the prime sieve filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module psf_checker #(
	parameter int VALUE_BITS = 16
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cand_valid,
	input logic                  cand_ready,
	input logic [VALUE_BITS-1:0] candidate,
	input logic                  restart,
	input logic                  prime_valid,
	input logic                  prime_ready,
	input logic [VALUE_BITS-1:0] prime,
	input logic                  store_full
);

	logic cand_acc;

	assign cand_acc = cand_valid && cand_ready;

	// a stalled result holds its word
	`ASSERT_NEXT(a_out_hold, clk, arst_n, prime_valid && !prime_ready,
		prime_valid && $stable(prime) && $stable(store_full))

	// one word in flight: no accept right after an accept
	`ASSERT_NEXT(a_one_in_flight, clk, arst_n, cand_acc, !cand_ready)

	// a result is loaded only when the sequencer is busy finishing a word
	`ASSERT_IMPLY(a_load_busy, clk, arst_n, $rose(prime_valid), !$past(cand_ready))

	// a waiting candidate word holds until taken
	`ASSERT_NEXT(a_in_hold, clk, arst_n, cand_valid && !cand_ready,
		cand_valid && $stable(candidate) && $stable(restart))

endmodule

bind prime_sieve_filter psf_checker #(
	.VALUE_BITS (VALUE_BITS)
) u_psf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cand_valid  (cand_valid),
	.cand_ready  (cand_ready),
	.candidate   (candidate),
	.restart     (restart),
	.prime_valid (prime_valid),
	.prime_ready (prime_ready),
	.prime       (prime),
	.store_full  (store_full)
);
